// File: hw/rtl/quaternion_vector_rotate_unit_macros.svh
// ----------------------------------------------------------------------------
// Quaternion vector rotate unit: assertion macros
// Shared concurrent assertion forms, all clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_VECTOR_ROTATE_UNIT_MACROS_SVH
`define QUATERNION_VECTOR_ROTATE_UNIT_MACROS_SVH

// Whenever ante holds, cons must hold in the same cycle.
`define QVR_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Whenever ante holds, cons must hold in the next cycle.
`define QVR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/qvr_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion vector rotate: package
// Widths, register indexes, status codes and shared types.
// ----------------------------------------------------------------------------
package qvr_pkg;

	localparam int QUAT_W  = 18;   // quaternion part, Q2.16
	localparam int COORD_W = 32;   // point coordinate, Q16.16
	localparam int P1_W    = QUAT_W + COORD_W;   // first products
	localparam int F_W     = P1_W + 2;           // parts of q*(0,v)
	localparam int P2_W    = F_W + QUAT_W;       // second products
	localparam int NUM_W   = P2_W + 2;           // numerators
	localparam int NORM_W  = 2 * QUAT_W + 1;     // sum of squares
	localparam int IDX_W   = 2;
	localparam int DIV_STEPS   = COORD_W;
	localparam int PROD_STAGES = 4;
	localparam int DIV_STAGES  = DIV_STEPS + 3;
	localparam int PIPE_DEPTH  = PROD_STAGES + DIV_STAGES;

	localparam logic [IDX_W-1:0] REG_QUAT_W = 2'd0;
	localparam logic [IDX_W-1:0] REG_QUAT_I = 2'd1;
	localparam logic [IDX_W-1:0] REG_QUAT_J = 2'd2;
	localparam logic [IDX_W-1:0] REG_QUAT_K = 2'd3;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_ZERO = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [QUAT_W-1:0] w;
		logic signed [QUAT_W-1:0] i;
		logic signed [QUAT_W-1:0] j;
		logic signed [QUAT_W-1:0] k;
	} quat_t;

endpackage

// File: hw/rtl/point_if.sv
// ----------------------------------------------------------------------------
// Point channel
// Valid/ready channel carrying one Q16.16 point per item.
// ----------------------------------------------------------------------------
interface point_if;
	logic valid;
	logic ready;
	logic signed [qvr_pkg::COORD_W-1:0] point_x;
	logic signed [qvr_pkg::COORD_W-1:0] point_y;
	logic signed [qvr_pkg::COORD_W-1:0] point_z;

	modport source (output valid, point_x, point_y, point_z, input ready);
	modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

// File: hw/rtl/rotated_if.sv
// ----------------------------------------------------------------------------
// Rotated point channel
// Valid/ready channel carrying one rotated point and its status per item.
// ----------------------------------------------------------------------------
interface rotated_if;
	logic valid;
	logic ready;
	logic signed [qvr_pkg::COORD_W-1:0] rotated_x;
	logic signed [qvr_pkg::COORD_W-1:0] rotated_y;
	logic signed [qvr_pkg::COORD_W-1:0] rotated_z;
	logic [1:0] status;

	modport source (output valid, rotated_x, rotated_y, rotated_z, status, input ready);
	modport sink (input valid, rotated_x, rotated_y, rotated_z, status, output ready);
endinterface

// File: hw/rtl/qvr_product.sv
// ----------------------------------------------------------------------------
// Quaternion vector rotate: product pipeline
// Four stages forming the exact numerators of q * (0,v) * conj(q).
// ----------------------------------------------------------------------------
module qvr_product (
	input  logic                                   clk,
	input  logic                                   en,
	input  qvr_pkg::quat_t                         quat,
	input  logic signed [qvr_pkg::COORD_W-1:0]     x,
	input  logic signed [qvr_pkg::COORD_W-1:0]     y,
	input  logic signed [qvr_pkg::COORD_W-1:0]     z,
	output logic signed [qvr_pkg::NUM_W-1:0]       nx,
	output logic signed [qvr_pkg::NUM_W-1:0]       ny,
	output logic signed [qvr_pkg::NUM_W-1:0]       nz
);

	logic signed [qvr_pkg::P1_W-1:0] wx_s1, wy_s1, wz_s1, ax_s1, ay_s1, az_s1;
	logic signed [qvr_pkg::P1_W-1:0] bx_s1, by_s1, bz_s1, cx_s1, cy_s1, cz_s1;
	logic signed [qvr_pkg::F_W-1:0]  fw_s2, fi_s2, fj_s2, fk_s2;
	logic signed [qvr_pkg::P2_W-1:0] wa_s3, wb_s3, wc_s3, iw_s3, ic_s3, ib_s3;
	logic signed [qvr_pkg::P2_W-1:0] jc_s3, jw_s3, ja_s3, kb_s3, ka_s3, kw_s3;
	logic signed [qvr_pkg::NUM_W-1:0] nx_s4, ny_s4, nz_s4;

	// Stage 1: quaternion parts times coordinates.
	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= quat.w * x;  wy_s1 <= quat.w * y;  wz_s1 <= quat.w * z;
			ax_s1 <= quat.i * x;  ay_s1 <= quat.i * y;  az_s1 <= quat.i * z;
			bx_s1 <= quat.j * x;  by_s1 <= quat.j * y;  bz_s1 <= quat.j * z;
			cx_s1 <= quat.k * x;  cy_s1 <= quat.k * y;  cz_s1 <= quat.k * z;
		end
	end

	// Stage 2: the four parts of q * (0,v).
	always_ff @(posedge clk) begin
		if (en) begin
			fw_s2 <= -qvr_pkg::F_W'(ax_s1) - qvr_pkg::F_W'(by_s1) - qvr_pkg::F_W'(cz_s1);
			fi_s2 <= qvr_pkg::F_W'(wx_s1) + qvr_pkg::F_W'(bz_s1) - qvr_pkg::F_W'(cy_s1);
			fj_s2 <= qvr_pkg::F_W'(wy_s1) - qvr_pkg::F_W'(az_s1) + qvr_pkg::F_W'(cx_s1);
			fk_s2 <= qvr_pkg::F_W'(wz_s1) + qvr_pkg::F_W'(ay_s1) - qvr_pkg::F_W'(bx_s1);
		end
	end

	// Stage 3: products with conj(q).
	always_ff @(posedge clk) begin
		if (en) begin
			wa_s3 <= fw_s2 * quat.i;  wb_s3 <= fw_s2 * quat.j;  wc_s3 <= fw_s2 * quat.k;
			iw_s3 <= fi_s2 * quat.w;  ic_s3 <= fi_s2 * quat.k;  ib_s3 <= fi_s2 * quat.j;
			jc_s3 <= fj_s2 * quat.k;  jw_s3 <= fj_s2 * quat.w;  ja_s3 <= fj_s2 * quat.i;
			kb_s3 <= fk_s2 * quat.j;  ka_s3 <= fk_s2 * quat.i;  kw_s3 <= fk_s2 * quat.w;
		end
	end

	// Stage 4: vector part of the second product.
	always_ff @(posedge clk) begin
		if (en) begin
			nx_s4 <= -qvr_pkg::NUM_W'(wa_s3) + qvr_pkg::NUM_W'(iw_s3)
				- qvr_pkg::NUM_W'(jc_s3) + qvr_pkg::NUM_W'(kb_s3);
			ny_s4 <= -qvr_pkg::NUM_W'(wb_s3) + qvr_pkg::NUM_W'(ic_s3)
				+ qvr_pkg::NUM_W'(jw_s3) - qvr_pkg::NUM_W'(ka_s3);
			nz_s4 <= -qvr_pkg::NUM_W'(wc_s3) - qvr_pkg::NUM_W'(ib_s3)
				+ qvr_pkg::NUM_W'(ja_s3) + qvr_pkg::NUM_W'(kw_s3);
		end
	end

	assign nx = nx_s4;
	assign ny = ny_s4;
	assign nz = nz_s4;

endmodule

// File: hw/rtl/qvr_divider.sv
// ----------------------------------------------------------------------------
// Quaternion vector rotate: divider lane
// Pipelined restoring division, one quotient bit per stage, with saturation.
// ----------------------------------------------------------------------------
module qvr_divider (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [qvr_pkg::NUM_W-1:0]    num,
	input  logic [qvr_pkg::NORM_W-1:0]          norm,
	output logic signed [qvr_pkg::COORD_W-1:0]  value,
	output logic                                sat
);

	localparam int HI_W = qvr_pkg::NUM_W - qvr_pkg::COORD_W;

	logic                              neg_s1;
	logic [qvr_pkg::NUM_W-1:0]         mag_s1;
	logic [qvr_pkg::NORM_W-1:0]        rem_s  [qvr_pkg::DIV_STEPS+1];
	logic [qvr_pkg::COORD_W-1:0]       low_s  [qvr_pkg::DIV_STEPS+1];
	logic [qvr_pkg::COORD_W-1:0]       quo_s  [qvr_pkg::DIV_STEPS+1];
	logic                              neg_s  [qvr_pkg::DIV_STEPS+1];
	logic                              ovf_s  [qvr_pkg::DIV_STEPS+1];
	logic signed [qvr_pkg::COORD_W-1:0] value_s3;
	logic                              sat_s3;
	logic [qvr_pkg::COORD_W-1:0]       quo_last;
	logic                              big;

	// Sign and magnitude.
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= num[qvr_pkg::NUM_W-1];
			mag_s1 <= num[qvr_pkg::NUM_W-1] ? qvr_pkg::NUM_W'(-num) : qvr_pkg::NUM_W'(num);
		end
	end

	// If the upper part already reaches the divisor the quotient needs more
	// than 32 bits and saturates; otherwise it seeds the partial remainder.
	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= mag_s1[qvr_pkg::NUM_W-1:qvr_pkg::COORD_W] >= HI_W'(norm);
			rem_s[0] <= mag_s1[qvr_pkg::COORD_W+qvr_pkg::NORM_W-1:qvr_pkg::COORD_W];
			low_s[0] <= mag_s1[qvr_pkg::COORD_W-1:0];
			quo_s[0] <= '0;
			neg_s[0] <= neg_s1;
		end
	end

	for (genvar g = 0; g < qvr_pkg::DIV_STEPS; g++) begin : g_step
		logic [qvr_pkg::NORM_W:0] trial;
		logic                     ge;

		always_comb begin
			trial = {rem_s[g], low_s[g][qvr_pkg::COORD_W-1]};
			ge    = trial >= {1'b0, norm};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1] <= ge ? qvr_pkg::NORM_W'(trial - {1'b0, norm})
					: trial[qvr_pkg::NORM_W-1:0];
				low_s[g+1] <= {low_s[g][qvr_pkg::COORD_W-2:0], 1'b0};
				quo_s[g+1] <= {quo_s[g][qvr_pkg::COORD_W-2:0], ge};
				neg_s[g+1] <= neg_s[g];
				ovf_s[g+1] <= ovf_s[g];
			end
		end
	end

	// A negative result may reach 2^31, a positive one only 2^31 - 1.
	always_comb begin
		quo_last = quo_s[qvr_pkg::DIV_STEPS];
		big = neg_s[qvr_pkg::DIV_STEPS]
			? (quo_last > {1'b1, {(qvr_pkg::COORD_W-1){1'b0}}})
			: quo_last[qvr_pkg::COORD_W-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sat_s3 <= ovf_s[qvr_pkg::DIV_STEPS] | big;
			if (ovf_s[qvr_pkg::DIV_STEPS] | big) begin
				value_s3 <= neg_s[qvr_pkg::DIV_STEPS]
					? {1'b1, {(qvr_pkg::COORD_W-1){1'b0}}}
					: {1'b0, {(qvr_pkg::COORD_W-1){1'b1}}};
			end else begin
				value_s3 <= neg_s[qvr_pkg::DIV_STEPS] ? -quo_last : quo_last;
			end
		end
	end

	assign value = value_s3;
	assign sat   = sat_s3;

endmodule

// File: hw/rtl/quaternion_vector_rotate_unit.sv
// ----------------------------------------------------------------------------
// Quaternion vector rotate unit
// Rotates Q16.16 points by the configured quaternion as q * (0,v) * q^-1.
// ----------------------------------------------------------------------------
// The unit takes one point per cycle while the output side is not stalling
// and returns the rotated points in the order they were accepted. Four
// stages build the exact numerators of both Hamilton products; three divider
// lanes then divide by the squared norm w^2+i^2+j^2+k^2 with one quotient bit
// per stage (32 stages plus sign, setup and clamp stages), which sets the
// latency. The quotient rounds toward zero; a result beyond the Q16.16 range
// is clamped and status reports a saturation. An all-zero quaternion yields
// zero coordinates with the zero-quaternion status. The whole pipeline
// advances together: it moves whenever the last stage is empty or its item is
// being taken, so a stall on the output holds every stage and loses nothing.
// Quaternion registers are written through cfg_we/cfg_idx/cfg_wdata and must
// only be changed while no item is in flight.
// ----------------------------------------------------------------------------
`include "quaternion_vector_rotate_unit_macros.svh"

module quaternion_vector_rotate_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [qvr_pkg::IDX_W-1:0]         cfg_idx,
	input  logic [qvr_pkg::QUAT_W-1:0]        cfg_wdata,
	point_if.sink                             pt_in,
	rotated_if.source                         rot_out
);

	qvr_pkg::quat_t                      quat_q;
	logic [qvr_pkg::NORM_W-1:0]          norm_q;
	logic [qvr_pkg::PIPE_DEPTH-1:0]      vld_q;
	logic                                adv;
	logic signed [qvr_pkg::NUM_W-1:0]    nx, ny, nz;
	logic signed [qvr_pkg::COORD_W-1:0]  vx, vy, vz;
	logic                                sx, sy, sz;
	logic                                zero_q;

	// Configuration registers; writes beyond the last register are dropped
	// because the two-bit index covers exactly the four parts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_q.w <= qvr_pkg::QUAT_W'(65536);
			quat_q.i <= '0;
			quat_q.j <= '0;
			quat_q.k <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				qvr_pkg::REG_QUAT_W: quat_q.w <= cfg_wdata;
				qvr_pkg::REG_QUAT_I: quat_q.i <= cfg_wdata;
				qvr_pkg::REG_QUAT_J: quat_q.j <= cfg_wdata;
				qvr_pkg::REG_QUAT_K: quat_q.k <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// The squared norm follows the registers in the next cycle; it is first
	// needed deep in the divider, long after any item can enter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_q <= qvr_pkg::NORM_W'(64'h1_0000_0000);
		end else begin
			norm_q <= qvr_pkg::NORM_W'(quat_q.w * quat_q.w) + qvr_pkg::NORM_W'(quat_q.i * quat_q.i)
				+ qvr_pkg::NORM_W'(quat_q.j * quat_q.j) + qvr_pkg::NORM_W'(quat_q.k * quat_q.k);
		end
	end

	assign zero_q = (norm_q == '0);

	// Global advance: every stage moves when the last one can drain.
	assign adv = !vld_q[qvr_pkg::PIPE_DEPTH-1] || rot_out.ready;
	assign pt_in.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[qvr_pkg::PIPE_DEPTH-2:0], pt_in.valid};
		end
	end

	qvr_product u_product (
		.clk  (clk),
		.en   (adv),
		.quat (quat_q),
		.x    (pt_in.point_x),
		.y    (pt_in.point_y),
		.z    (pt_in.point_z),
		.nx   (nx),
		.ny   (ny),
		.nz   (nz)
	);

	qvr_divider u_div_x (.clk(clk), .en(adv), .num(nx), .norm(norm_q), .value(vx), .sat(sx));
	qvr_divider u_div_y (.clk(clk), .en(adv), .num(ny), .norm(norm_q), .value(vy), .sat(sy));
	qvr_divider u_div_z (.clk(clk), .en(adv), .num(nz), .norm(norm_q), .value(vz), .sat(sz));

	// A zero quaternion overrides whatever the divider produced.
	always_comb begin
		rot_out.valid = vld_q[qvr_pkg::PIPE_DEPTH-1];
		if (zero_q) begin
			rot_out.rotated_x = '0;
			rot_out.rotated_y = '0;
			rot_out.rotated_z = '0;
			rot_out.status    = qvr_pkg::ST_ZERO;
		end else begin
			rot_out.rotated_x = vx;
			rot_out.rotated_y = vy;
			rot_out.rotated_z = vz;
			rot_out.status    = (sx | sy | sz) ? qvr_pkg::ST_SAT : qvr_pkg::ST_OK;
		end
	end

	`QVR_ASSERT_IMPL(a_stall_blocks_input, rot_out.valid && !rot_out.ready, !pt_in.ready,
		"input accepted while the output stalls")
	`QVR_ASSERT_NEXT(a_stall_holds_last, rot_out.valid && !rot_out.ready, rot_out.valid,
		"last stage lost its item during a stall")
	`QVR_ASSERT_IMPL(a_zero_status, rot_out.valid && norm_q == '0,
		rot_out.status == qvr_pkg::ST_ZERO && rot_out.rotated_x == '0,
		"zero quaternion without zero status")
	`QVR_ASSERT_IMPL(a_sat_at_limit, rot_out.valid && rot_out.status == qvr_pkg::ST_SAT,
		sx || sy || sz, "saturation status without a clamped lane")

endmodule

// File: verif/quaternion_vector_rotate_unit_tb.sv
// ----------------------------------------------------------------------------
// Quaternion vector rotate unit: testbench
// Streams points through the rotator under several quaternion settings and
// compares every rotated point and its status against a predictor.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_unit_tb;

	typedef struct {
		logic signed [qvr_pkg::COORD_W-1:0] x;
		logic signed [qvr_pkg::COORD_W-1:0] y;
		logic signed [qvr_pkg::COORD_W-1:0] z;
		qvr_pkg::status_t                   status;
	} rotated_point_t;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [qvr_pkg::IDX_W-1:0]   cfg_idx;
	logic [qvr_pkg::QUAT_W-1:0]  cfg_wdata;

	point_if   pt_in ();
	rotated_if rot_out ();

	quaternion_vector_rotate_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.pt_in    (pt_in),
		.rot_out  (rot_out)
	);

	// Shadow copy of the quaternion registers, kept in step with every write.
	qvr_pkg::quat_t cur_quat;
	rotated_point_t pending_points[$];
	int             error_count;
	bit             idle_en;
	int             stall_left;

	always #10 clk = ~clk;

	// Rotates one point by q * (0,v) * conj(q) / |q|^2. All arithmetic is done
	// at 128 bits so that both Hamilton products stay exact.
	function automatic rotated_point_t rotate_point(qvr_pkg::quat_t q, logic signed [31:0] px,
			logic signed [31:0] py, logic signed [31:0] pz);
		logic signed [127:0] w, a, b, c, x, y, z, n;
		logic signed [127:0] fw, fi, fj, fk;
		logic signed [127:0] num[3];
		logic signed [127:0] quo;
		rotated_point_t r;
		bit sat;
		w = q.w; a = q.i; b = q.j; c = q.k;
		x = px; y = py; z = pz;
		n = w * w + a * a + b * b + c * c;
		sat = 0;
		if (n == 0) begin
			r.x = '0; r.y = '0; r.z = '0;
			r.status = qvr_pkg::ST_ZERO;
			return r;
		end
		fw = -(a * x) - b * y - c * z;
		fi = w * x + b * z - c * y;
		fj = w * y - a * z + c * x;
		fk = w * z + a * y - b * x;
		num[0] = (-fw) * a + fi * w + (-fj) * c + fk * b;
		num[1] = (-fw) * b + fi * c + fj * w + (-fk) * a;
		num[2] = (-fw) * c + (-fi) * b + fj * a + fk * w;
		for (int m = 0; m < 3; m++) begin
			// Signed division in SystemVerilog truncates toward zero.
			quo = num[m] / n;
			if (quo > 128'sd2147483647) begin
				quo = 128'sd2147483647;
				sat = 1;
			end else if (quo < -128'sd2147483648) begin
				quo = -128'sd2147483648;
				sat = 1;
			end
			num[m] = quo;
		end
		r.x = num[0][31:0];
		r.y = num[1][31:0];
		r.z = num[2][31:0];
		r.status = sat ? qvr_pkg::ST_SAT : qvr_pkg::ST_OK;
		return r;
	endfunction

	// The receiver stalls in bursts of random length while idling is enabled.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			rot_out.ready = 1'b0;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 7);
			rot_out.ready = 1'b0;
		end else begin
			rot_out.ready = 1'b1;
		end
	end

	// Every item taken on the output side is checked against the oldest
	// expected point.
	always @(posedge clk) begin
		rotated_point_t e;
		if (arst_n && rot_out.valid && rot_out.ready) begin
			if (pending_points.size() == 0) begin
				$error("unexpected item: x=%0d y=%0d z=%0d status=%0d",
					rot_out.rotated_x, rot_out.rotated_y, rot_out.rotated_z,
					rot_out.status);
				error_count++;
			end else begin
				e = pending_points.pop_front();
				if (rot_out.rotated_x !== e.x) begin
					$error("rotated_x: expected %0d, actual %0d", e.x, rot_out.rotated_x);
					error_count++;
				end
				if (rot_out.rotated_y !== e.y) begin
					$error("rotated_y: expected %0d, actual %0d", e.y, rot_out.rotated_y);
					error_count++;
				end
				if (rot_out.rotated_z !== e.z) begin
					$error("rotated_z: expected %0d, actual %0d", e.z, rot_out.rotated_z);
					error_count++;
				end
				if (rot_out.status !== e.status) begin
					$error("status: expected %0d, actual %0d", e.status, rot_out.status);
					error_count++;
				end
			end
		end
	end

	// Sends one point. It starts and ends at a falling edge and leaves valid
	// high, so back-to-back items keep valid high unless idling inserts a gap.
	task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			pt_in.valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		pt_in.valid = 1'b1;
		pt_in.point_x = x;
		pt_in.point_y = y;
		pt_in.point_z = z;
		do @(posedge clk); while (!pt_in.ready);
		pending_points.push_back(rotate_point(cur_quat, x, y, z));
		@(negedge clk);
	endtask

	// Waits for the pipeline to empty, then lets the latency pass.
	task automatic drain_pipeline();
		pt_in.valid = 1'b0;
		while (pending_points.size() != 0) @(negedge clk);
		repeat (qvr_pkg::PIPE_DEPTH + 10) @(negedge clk);
	endtask

	// Register writes happen only once every expected point has come back.
	task automatic write_quat(qvr_pkg::quat_t q);
		drain_pipeline();
		for (int m = 0; m < 4; m++) begin
			cfg_we = 1'b1;
			case (m)
				0: begin cfg_idx = qvr_pkg::REG_QUAT_W; cfg_wdata = q.w; end
				1: begin cfg_idx = qvr_pkg::REG_QUAT_I; cfg_wdata = q.i; end
				2: begin cfg_idx = qvr_pkg::REG_QUAT_J; cfg_wdata = q.j; end
				default: begin cfg_idx = qvr_pkg::REG_QUAT_K; cfg_wdata = q.k; end
			endcase
			@(negedge clk);
		end
		cfg_we = 1'b0;
		cur_quat = q;
	endtask

	// Coordinates mix full-range values, small values and the extremes.
	function automatic logic [31:0] pick_coord();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			1: return $urandom_range(0, 1 << 21) - (1 << 20);
			2: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic qvr_pkg::quat_t pick_quat(int kind);
		qvr_pkg::quat_t q;
		case (kind)
			// Tiny parts make the norm small.
			0: begin
				q.w = $urandom_range(0, 32) - 16; q.i = $urandom_range(0, 32) - 16;
				q.j = $urandom_range(0, 32) - 16; q.k = $urandom_range(0, 32) - 16;
			end
			// Rotations about a random axis, each part within about +-0.71.
			1: begin
				q.w = $urandom_range(0, 92682) - 46341; q.i = $urandom_range(0, 92682) - 46341;
				q.j = $urandom_range(0, 92682) - 46341; q.k = $urandom_range(0, 92682) - 46341;
			end
			default: begin
				q.w = $urandom; q.i = $urandom; q.j = $urandom; q.k = $urandom;
			end
		endcase
		return q;
	endfunction

	task automatic test_identity_extremes();
		// Reset value is the identity, so points come back unchanged.
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
		send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001);
		send_point(32'h0, 32'h0, 32'h0);
	endtask

	task automatic test_zero_quaternion();
		write_quat('{w: 0, i: 0, j: 0, k: 0});
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
		send_point(32'h0, 32'h0, 32'h0);
	endtask

	task automatic test_quat_extremes();
		// All parts most negative, then all most positive, then single parts alone.
		write_quat('{w: 18'h20000, i: 18'h20000, j: 18'h20000, k: 18'h20000});
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_point(32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000);
		write_quat('{w: 18'h1FFFF, i: 18'h1FFFF, j: 18'h1FFFF, k: 18'h1FFFF});
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_point(32'h0001_0000, 32'h0, 32'h0);
		write_quat('{w: 0, i: 18'h10000, j: 0, k: 0});
		send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
		write_quat('{w: 0, i: 0, j: 18'h20000, k: 0});
		send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
		write_quat('{w: 0, i: 0, j: 0, k: 18'h1FFFF});
		send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
	endtask

	task automatic test_saturation();
		// A norm of one LSB still rotates by the identity: every coordinate stays in the Q16.16 range.
		write_quat('{w: 1, i: 0, j: 0, k: 0});
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
		send_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h0);
		write_quat('{w: 18'h08000, i: 18'h38000, j: 18'h08000, k: 18'h38000});
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
	endtask

	task automatic test_random_stream(int phases, int items_per_phase);
		for (int p = 0; p < phases; p++) begin
			write_quat(pick_quat(p % 3));
			for (int m = 0; m < items_per_phase; m++)
				send_point(pick_coord(), pick_coord(), pick_coord());
		end
	endtask

	task automatic test_drain_pause();
		// The sender holds off until every expected point has arrived.
		write_quat(pick_quat(1));
		for (int m = 0; m < 20; m++) begin
			send_point(pick_coord(), pick_coord(), pick_coord());
			if (m % 5 == 4) begin
				pt_in.valid = 1'b0;
				while (pending_points.size() != 0) @(negedge clk);
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = qvr_pkg::REG_QUAT_W;
		cfg_wdata = '0;
		pt_in.valid = 1'b0;
		pt_in.point_x = '0;
		pt_in.point_y = '0;
		pt_in.point_z = '0;
		rot_out.ready = 1'b0;
		cur_quat = '{w: 18'h10000, i: 0, j: 0, k: 0};
		error_count = 0;
		idle_en = 1'b1;
		stall_left = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_identity_extremes();
		test_zero_quaternion();
		test_quat_extremes();
		test_saturation();
		test_random_stream(12, 95);
		test_drain_pause();
		// The last stretch runs at full rate on both sides.
		idle_en = 1'b0;
		test_random_stream(2, 100);

		drain_pipeline();
		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Watchdog well beyond the slowest legal run.
	initial begin
		#20000000;
		$display("tb: failure");
		$finish;
	end

endmodule
